// ===== rtl/core/delimited_token_extractor_core_assert.svh =====
// Assertion macros for the delimited token extractor core
`ifndef DELIMITED_TOKEN_EXTRACTOR_CORE_ASSERT_SVH
`define DELIMITED_TOKEN_EXTRACTOR_CORE_ASSERT_SVH
// same-cycle implication
`define DTE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define DTE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/dte_pkg.sv =====
// Package: types, constants and per-character scan function of the token extractor
`timescale 1ns / 1ps
package dte_pkg;
  localparam int StoreDepth = 63;
  localparam int StoreAw = $clog2(StoreDepth);
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChNl = 8'h0A;
  localparam logic [15:0] PosMax = 16'hFFFF;

  localparam logic [1:0] StFound = 2'd0;
  localparam logic [1:0] StNone = 2'd1;
  localparam logic [1:0] StBad = 2'd2;
  localparam logic [1:0] StCount = 2'd3;

  localparam logic [2:0] RegSep = 3'd0;
  localparam logic [2:0] RegQuote = 3'd1;
  localparam logic [2:0] RegIndex = 3'd2;
  localparam logic [2:0] RegCount = 3'd3;
  localparam logic [2:0] RegBuf = 3'd4;

  typedef enum logic [1:0] {PH_LEAD, PH_PLAIN, PH_QUOTED, PH_AFTERQ} phase_t;

  typedef struct packed {
    logic [7:0]  separator;
    logic [7:0]  quote_char;
    logic [15:0] token_index;
    logic        count_only;
    logic [6:0]  buffer_size;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] pos;
    logic [16:0] seen;
    logic [15:0] raw;
    logic [15:0] trim;
  } scan_t;

  typedef struct packed {
    scan_t              s;
    logic               fin;
    logic [1:0]         st;
    logic [15:0]        len;
    logic               we;
    logic [StoreAw-1:0] wa;
  } res_t;

  function automatic scan_t adv(scan_t s);
    scan_t t;
    t = s;
    if (s.pos != PosMax) t.pos = s.pos + 16'd1;
    return t;
  endfunction

  function automatic logic is_term(cfg_t g, logic [7:0] c);
    return (c == 8'd0) || (g.separator != ChNl && c == ChNl);
  endfunction

  function automatic logic target(cfg_t g, logic [16:0] seen);
    return !g.count_only && !seen[16] && (seen[15:0] >= g.token_index);
  endfunction

  function automatic res_t no_more(cfg_t g, res_t r);
    res_t t;
    t = r;
    t.fin = 1'b1;
    t.st = g.count_only ? StCount : StNone;
    return t;
  endfunction

  function automatic res_t store(res_t r, logic [7:0] c);
    res_t t;
    t = r;
    if (r.s.raw < 16'(StoreDepth)) begin
      t.we = 1'b1;
      t.wa = r.s.raw[StoreAw-1:0];
    end
    if (r.s.raw != 16'hFFFF) t.s.raw = r.s.raw + 16'd1;
    return t;
  endfunction

  function automatic res_t complete(cfg_t g, res_t r, logic [7:0] c, logic [15:0] len);
    res_t t;
    t = r;
    if (t.s.seen != 17'h0FFFF) t.s.seen = t.s.seen + 17'd1;
    if (is_term(g, c)) begin
      if (target(g, t.s.seen)) begin
        t.fin = 1'b1;
        t.st = StFound;
        t.len = len;
      end else begin
        t = no_more(g, t);
      end
    end else begin
      t.s = adv(t.s);
      if (target(g, t.s.seen)) begin
        t.fin = 1'b1;
        t.st = StFound;
        t.len = len;
      end else begin
        t.s.phase = PH_LEAD;
        t.s.raw = 16'd0;
        t.s.trim = 16'd0;
      end
    end
    return t;
  endfunction

  function automatic res_t plain(cfg_t g, res_t r, logic [7:0] c);
    res_t t;
    logic stop;
    logic blank;
    t = r;
    blank = (c == ChSpace) || (g.separator != ChTab && c == ChTab);
    if (g.separator == ChSpace)
      stop = c == 8'd0 || c == ChSpace || c == ChTab || c == ChNl;
    else
      stop = c == 8'd0 || c == ChNl || c == g.separator;
    if (g.quote_char != 8'd0 && c == g.quote_char) begin
      t.fin = 1'b1;
      t.st = StBad;
    end else if (!stop) begin
      t = store(t, c);
      if (!blank) t.s.trim = t.s.raw;
      t.s = adv(t.s);
    end else if (g.separator == ChSpace) begin
      t = complete(g, t, c, t.s.raw);
    end else if (c != g.separator && t.s.trim == 16'd0) begin
      t = no_more(g, t);
    end else begin
      t = complete(g, t, c, t.s.trim);
    end
    return t;
  endfunction

  function automatic res_t proc(cfg_t g, scan_t s, logic [7:0] c);
    res_t r;
    logic blank;
    logic isq;
    logic ok;
    r = '0;
    r.s = s;
    blank = (c == ChSpace) || (g.separator != ChTab && c == ChTab);
    isq = g.quote_char != 8'd0 && c == g.quote_char;
    ok = 1'b0;
    unique case (s.phase)
      PH_LEAD: begin
        if (s.pos == 16'd0 && s.seen[16] && is_term(g, c)) begin
          r.fin = 1'b1;
          r.st = StNone;
        end else if (blank) begin
          r.s = adv(r.s);
        end else begin
          r.s.raw = 16'd0;
          r.s.trim = 16'd0;
          if (isq) begin
            r.s = adv(r.s);
            r.s.phase = PH_QUOTED;
          end else if (g.separator == ChSpace && (c == 8'd0 || c == ChNl)) begin
            r = no_more(g, r);
          end else begin
            r.s.phase = PH_PLAIN;
            r = plain(g, r, c);
          end
        end
      end
      PH_PLAIN: r = plain(g, r, c);
      PH_QUOTED: begin
        if (isq) begin
          r.s = adv(r.s);
          r.s.phase = PH_AFTERQ;
        end else if (c == 8'd0 || c == ChNl) begin
          r.fin = 1'b1;
          r.st = StBad;
        end else begin
          r = store(r, c);
          r.s = adv(r.s);
        end
      end
      default: begin
        if (g.separator == ChSpace) begin
          ok = c == ChSpace || c == ChTab || c == ChNl || c == 8'd0;
          if (!ok) begin
            r.fin = 1'b1;
            r.st = StBad;
          end else begin
            r = complete(g, r, c, r.s.raw);
          end
        end else if (blank) begin
          r.s = adv(r.s);
        end else begin
          ok = c == g.separator || c == ChNl || c == 8'd0;
          if (!ok) begin
            r.fin = 1'b1;
            r.st = StBad;
          end else begin
            r = complete(g, r, c, r.s.raw);
          end
        end
      end
    endcase
    return r;
  endfunction
endpackage

// ===== rtl/core/delimited_token_extractor_core.sv =====
// Delimited token extractor: scans a line one character per transfer and returns the Nth token
// Takes one character per cycle while scanning. When a line is decided, input stalls while
// the clipped token is read back from the 63-entry token memory, one character per cycle
// while the output is ready, followed by one status transfer.
`timescale 1ns / 1ps
`include "delimited_token_extractor_core_assert.svh"
module delimited_token_extractor_core
  import dte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_char
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] token_char, [9:8] status, [25:10] end_offset,
                                 // [41:26] token_count, [47:42] zero
  output logic        m_tuser,   // [0] item_kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  scan_t scan;
  logic decided;
  logic [7:0] store_mem [StoreDepth];

  res_t r1, r2, rf;
  logic s_fire, line_end;
  logic [6:0] lim, clen;
  logic [15:0] fcnt;

  logic dr, rd_vld, mv, issue, stat_ld;
  logic [6:0] didx, dlen;
  logic [1:0] dst;
  logic [15:0] doff, dcnt;
  logic [7:0] rdata;

  logic o_vld, o_kind, o_last;
  logic [7:0] o_char;
  logic [1:0] o_st;
  logic [15:0] o_off, o_cnt;

  assign pready = 1'b1;
  assign s_tready = !dr;
  assign s_fire = s_tvalid && s_tready;
  assign line_end = s_tlast || is_term(cfg, s_tdata);

  always_comb begin
    r1 = proc(cfg, scan, s_tdata);
    r2 = proc(cfg, r1.s, 8'd0);
    rf = (!r1.fin && line_end) ? r2 : r1;
    lim = (cfg.buffer_size == 7'd0) ? 7'd0 : cfg.buffer_size - 7'd1;
    if (lim > 7'(StoreDepth)) lim = 7'(StoreDepth);
    clen = (rf.len > 16'(lim)) ? lim : rf.len[6:0];
    fcnt = (rf.s.seen == 17'h0FFFF) ? 16'hFFFF : 16'(rf.s.seen + 17'd1);
  end

  always_comb begin
    unique case (paddr[4:2])
      RegSep:   prdata = {24'd0, cfg.separator};
      RegQuote: prdata = {24'd0, cfg.quote_char};
      RegIndex: prdata = {16'd0, cfg.token_index};
      RegCount: prdata = {31'd0, cfg.count_only};
      RegBuf:   prdata = {25'd0, cfg.buffer_size};
      default:  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator <= ChSpace;
      cfg.quote_char <= 8'd0;
      cfg.token_index <= 16'd0;
      cfg.count_only <= 1'b0;
      cfg.buffer_size <= 7'd64;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        RegSep:   cfg.separator <= pwdata[7:0];
        RegQuote: cfg.quote_char <= pwdata[7:0];
        RegIndex: cfg.token_index <= pwdata[15:0];
        RegCount: cfg.count_only <= pwdata[0];
        RegBuf:   cfg.buffer_size <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && !decided && r1.we) store_mem[r1.wa] <= s_tdata;
    if (issue) rdata <= store_mem[didx[StoreAw-1:0]];
  end

  assign mv = rd_vld && (!o_vld || m_tready);
  assign issue = dr && (didx < dlen) && (!rd_vld || mv);
  assign stat_ld = dr && (didx == dlen) && !rd_vld && (!o_vld || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '{PH_LEAD, 16'd0, 17'h1FFFF, 16'd0, 16'd0};
      decided <= 1'b0;
      dr <= 1'b0;
      rd_vld <= 1'b0;
      didx <= 7'd0;
      dlen <= 7'd0;
      o_vld <= 1'b0;
    end else begin
      if (s_fire) begin
        if (line_end) begin
          scan <= '{PH_LEAD, 16'd0, 17'h1FFFF, 16'd0, 16'd0};
          decided <= 1'b0;
        end else if (!decided) begin
          scan <= rf.s;
          decided <= rf.fin;
        end
        if (!decided && rf.fin) begin
          dr <= 1'b1;
          didx <= 7'd0;
          dlen <= (rf.st == StFound) ? clen : 7'd0;
          dst <= rf.st;
          doff <= (rf.st == StFound) ? rf.s.pos : 16'd0;
          dcnt <= (rf.st == StCount) ? fcnt : 16'd0;
        end
      end
      if (issue) begin
        didx <= didx + 7'd1;
        rd_vld <= 1'b1;
      end else if (mv) begin
        rd_vld <= 1'b0;
      end
      if (mv) begin
        o_vld <= 1'b1;
        o_kind <= 1'b0;
        o_char <= rdata;
        o_st <= StFound;
        o_off <= 16'd0;
        o_cnt <= 16'd0;
        o_last <= 1'b0;
      end else if (stat_ld) begin
        o_vld <= 1'b1;
        o_kind <= 1'b1;
        o_char <= 8'd0;
        o_st <= dst;
        o_off <= doff;
        o_cnt <= dcnt;
        o_last <= 1'b1;
        dr <= 1'b0;
      end else if (m_tready) begin
        o_vld <= 1'b0;
      end
    end
  end

  assign m_tvalid = o_vld;
  assign m_tuser = o_kind;
  assign m_tlast = o_last;
  assign m_tdata = {6'd0, o_cnt, o_off, o_st, o_char};

  `DTE_ASSERT_IMP(a_rd_in_drain, rd_vld, dr, "read-back data outside a drain")
  `DTE_ASSERT_IMP(a_idx_bound, dr, didx <= dlen, "read-back index past token length")
  `DTE_ASSERT_IMP(a_status_last, o_vld && o_kind, o_last, "status result without last")
  `DTE_ASSERT_NXT(a_drain_blocks, dr && !stat_ld, !s_tready, "input taken during drain")

endmodule
